[hw/rtl/sntp_med_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntp median offset package
// shared types, register indexes, status codes and reset values
// ----------------------------------------------------------------------------
package sntp_med_pkg;

	localparam int WINDOW_SIZE_DEF = 9;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRATUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALIDITY    = 2'd1;

	localparam logic [7:0]  MAX_STRATUM_RST = 8'd14;
	// (4 * 60 + 3 * 60) * 2 seconds
	localparam logic [15:0] VALIDITY_RST    = 16'd840;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ALARM   = 2'd1;
	localparam logic [1:0] ST_STRATUM = 2'd2;

	localparam logic [1:0] LEAP_ALARM = 2'b11;

	// seconds from 1900 to 1970
	localparam logic [31:0] EPOCH_GAP = 32'h83AA7E80;

	typedef logic signed [31:0] offset_t;

	// per-cycle control broadcast to every window cell
	typedef struct packed {
		logic shift;
		logic cap_s2;
		logic cap_s3;
	} cell_ctl_t;

endpackage

[hw/rtl/sntp_med_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntp median window cell
// holds one window sample, ranks it against the whole window over two stages
// ----------------------------------------------------------------------------
module sntp_med_cell import sntp_med_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	parameter int IDX         = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cell_ctl_t                            ctl,
	input  offset_t                              prev_value,
	input  logic                                 prev_valid,
	input  offset_t [WINDOW_SIZE-1:0]            win_value,
	input  logic [WINDOW_SIZE-1:0]               win_valid,
	output offset_t                              value,
	output logic                                 valid,
	output offset_t                              value_s3,
	output logic                                 valid_s3,
	output logic [$clog2(WINDOW_SIZE+1)-1:0]     rank_s3
);

	localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

	offset_t                  value_q;
	logic                     valid_q;
	logic [WINDOW_SIZE-1:0]   prec_c;
	logic [WINDOW_SIZE-1:0]   prec_s2;
	offset_t                  value_s2;
	logic                     valid_s2;
	logic [CNT_W-1:0]         rank_c;
	offset_t                  val_s3;
	logic                     vld_s3;
	logic [CNT_W-1:0]         rnk_s3;

	// samples that sort ahead of this one, ties broken by position
	always_comb begin
		for (int j = 0; j < WINDOW_SIZE; j++) begin
			prec_c[j] = win_valid[j] && (j != IDX) &&
				(($signed(win_value[j]) < $signed(value_q)) ||
				 ((win_value[j] == value_q) && (j < IDX)));
		end
	end

	always_comb begin
		rank_c = '0;
		for (int j = 0; j < WINDOW_SIZE; j++) begin
			rank_c = rank_c + CNT_W'(prec_s2[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			valid_s2 <= 1'b0;
			vld_s3   <= 1'b0;
		end else begin
			if (ctl.shift) begin
				valid_q <= prev_valid;
			end
			if (ctl.cap_s2) begin
				valid_s2 <= valid_q;
			end
			if (ctl.cap_s3) begin
				vld_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= prev_value;
		end
		if (ctl.cap_s2) begin
			prec_s2  <= prec_c;
			value_s2 <= value_q;
		end
		if (ctl.cap_s3) begin
			rnk_s3 <= rank_c;
			val_s3 <= value_s2;
		end
	end

	assign value    = value_q;
	assign valid    = valid_q;
	assign value_s3 = val_s3;
	assign valid_s3 = vld_s3;
	assign rank_s3  = rnk_s3;

endmodule

[hw/rtl/sntp_reply_median_offset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntp reply median offset filter
// screens sntp replies and keeps the median clock offset of recent samples
// ----------------------------------------------------------------------------
// usage
//   in channel: one reply per transaction (header word, receive seconds,
//   local unix seconds). a reply with leap indicator 3 or a stratum of zero
//   or above max_stratum is rejected and leaves the window untouched.
//   out channel: one result per reply, in order: status, sample offset,
//   median system offset and the offset valid flag.
//   cfg channel: always ready; index 0 max_stratum, index 1 validity_seconds,
//   other indexes ignored. write only while no reply is in flight.
// timing
//   a result passes stages s1 to s4 and the output register to out_valid;
//   one reply per cycle while out_ready is high. the five register steps are
//   decode and window shift, pairwise compare in every cell, rank count in
//   every cell, middle select, and averaging into the output register.
// reset
//   arst_n empties the window, clears the median and restores register
//   defaults (stratum limit 14, validity 840 s).
// stall
//   while out_ready is low the pipeline fills its empty stages and then
//   drops in_ready; nothing is lost.
// ----------------------------------------------------------------------------
module sntp_reply_median_offset_top import sntp_med_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            header_word,
	input  logic [31:0]            receive_seconds,
	input  logic [30:0]            local_seconds,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic signed [31:0]     sample_offset,
	output logic signed [31:0]     system_offset,
	output logic                   offset_valid
);

	localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

	// configuration registers
	logic [7:0]  max_stratum_q;
	logic [15:0] validity_q;

	// filter state
	logic [CNT_W-1:0] count_q;
	logic [30:0]      last_update_q;
	logic             ever_q;
	offset_t          median_q;

	// reply decode
	logic [1:0]  leap_c;
	logic [7:0]  stratum_c;
	logic [1:0]  status_c;
	offset_t     sample_c;
	logic        take_c;
	logic        fresh_c;
	logic        in_accept;
	logic [31:0] expiry_c;

	// pipeline valids and enables
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic en_s2, en_s3, en_s4, en_out;

	// stage payloads
	logic [1:0]        status_s1, status_s2, status_s3, status_s4;
	offset_t           sample_s1, sample_s2, sample_s3, sample_s4;
	logic              fresh_s1, fresh_s2, fresh_s3, fresh_s4;
	logic [CNT_W-1:0]  count_s2, count_s3;
	logic              even_s4;
	offset_t           mid_hi_s4, mid_lo_s4;

	// output register
	logic [1:0] status_q;
	offset_t    sample_q;
	offset_t    system_q;
	logic       fresh_q;

	// cell chain
	cell_ctl_t                      ctl;
	offset_t [WINDOW_SIZE-1:0]      win_value;
	logic [WINDOW_SIZE-1:0]         win_valid;
	offset_t [WINDOW_SIZE-1:0]      rank_value;
	logic [WINDOW_SIZE-1:0]         rank_valid;
	logic [WINDOW_SIZE-1:0][CNT_W-1:0] rank;

	// middle selection and averaging
	logic [CNT_W-1:0]   hi_tgt_c, lo_tgt_c;
	offset_t            mid_hi_c, mid_lo_c;
	logic signed [32:0] sum_c, adj_c;
	offset_t            mean_c, mid_c, median_c;

	// ---------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stratum_q <= MAX_STRATUM_RST;
			validity_q    <= VALIDITY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_STRATUM: max_stratum_q <= cfg_data[7:0];
				CFG_VALIDITY:    validity_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// handshake: each stage takes a transaction when empty or draining
	// ---------------------------------------------------------------------
	assign en_out    = !out_valid_q || out_ready;
	assign en_s4     = !v_s4 || en_out;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign in_ready  = !v_s1 || en_s2;
	assign in_accept = in_valid && in_ready;

	// ---------------------------------------------------------------------
	// reply screening, alarm checked ahead of stratum
	// ---------------------------------------------------------------------
	assign leap_c    = header_word[31:30];
	assign stratum_c = header_word[23:16];

	always_comb begin
		if (leap_c == LEAP_ALARM) begin
			status_c = ST_ALARM;
		end else if ((stratum_c == 8'd0) || (stratum_c > max_stratum_q)) begin
			status_c = ST_STRATUM;
		end else begin
			status_c = ST_OK;
		end
	end

	assign sample_c = (status_c == ST_OK) ?
		(receive_seconds - {1'b0, local_seconds} - EPOCH_GAP) : '0;
	assign take_c   = in_accept && (status_c == ST_OK);

	// an accepted sample is fresh by definition; otherwise check expiry
	assign expiry_c = {1'b0, last_update_q} + {16'd0, validity_q};
	assign fresh_c  = (status_c == ST_OK) ||
		(ever_q && (expiry_c >= {1'b0, local_seconds}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			last_update_q <= '0;
			ever_q        <= 1'b0;
		end else if (take_c) begin
			if (count_q != CNT_W'(WINDOW_SIZE)) begin
				count_q <= count_q + 1'b1;
			end
			last_update_q <= local_seconds;
			ever_q        <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// window: newest sample enters cell 0, the oldest falls off the end
	// ---------------------------------------------------------------------
	assign ctl.shift  = take_c;
	assign ctl.cap_s2 = en_s2;
	assign ctl.cap_s3 = en_s3;

	for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
		offset_t prev_value;
		logic    prev_valid;

		if (g == 0) begin : g_head
			assign prev_value = sample_c;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_value = win_value[g-1];
			assign prev_valid = win_valid[g-1];
		end

		sntp_med_cell #(
			.WINDOW_SIZE (WINDOW_SIZE),
			.IDX         (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.win_value  (win_value),
			.win_valid  (win_valid),
			.value      (win_value[g]),
			.valid      (win_valid[g]),
			.value_s3   (rank_value[g]),
			.valid_s3   (rank_valid[g]),
			.rank_s3    (rank[g])
		);
	end

	// ---------------------------------------------------------------------
	// pipeline stages s1 to s4; the cells track the same steps for ranking
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// middle ranks of the current window
	assign hi_tgt_c = count_s3 >> 1;
	assign lo_tgt_c = hi_tgt_c - 1'b1;

	always_comb begin
		mid_hi_c = '0;
		mid_lo_c = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			if (rank_valid[i] && (rank[i] == hi_tgt_c)) begin
				mid_hi_c = mid_hi_c | rank_value[i];
			end
			if (rank_valid[i] && (rank[i] == lo_tgt_c)) begin
				mid_lo_c = mid_lo_c | rank_value[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			status_s1 <= status_c;
			sample_s1 <= sample_c;
			fresh_s1  <= fresh_c;
		end
		if (en_s2) begin
			status_s2 <= status_s1;
			sample_s2 <= sample_s1;
			fresh_s2  <= fresh_s1;
			count_s2  <= count_q;
		end
		if (en_s3) begin
			status_s3 <= status_s2;
			sample_s3 <= sample_s2;
			fresh_s3  <= fresh_s2;
			count_s3  <= count_s2;
		end
		if (en_s4) begin
			status_s4 <= status_s3;
			sample_s4 <= sample_s3;
			fresh_s4  <= fresh_s3;
			even_s4   <= !count_s3[0];
			mid_hi_s4 <= mid_hi_c;
			mid_lo_s4 <= mid_lo_c;
		end
	end

	// ---------------------------------------------------------------------
	// even count: mean of the two middles, truncated toward zero
	// ---------------------------------------------------------------------
	assign sum_c  = {mid_hi_s4[31], mid_hi_s4} + {mid_lo_s4[31], mid_lo_s4};
	assign adj_c  = sum_c + {32'd0, sum_c[32]};
	assign mean_c = adj_c[32:1];
	assign mid_c  = even_s4 ? mean_c : mid_hi_s4;

	// a correction of one second either way is dropped
	assign median_c = ((mid_c == 32'sd1) || (mid_c == -32'sd1)) ? '0 : mid_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_q <= '0;
		end else if (en_out && v_s4 && (status_s4 == ST_OK)) begin
			median_q <= median_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			status_q <= status_s4;
			sample_q <= sample_s4;
			system_q <= (status_s4 == ST_OK) ? median_c : median_q;
			fresh_q  <= fresh_s4;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign sample_offset = sample_q;
	assign system_offset = system_q;
	assign offset_valid  = fresh_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_SIZE))
		else $error("sample count above window size");

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(win_valid) == int'(count_q))
		else $error("occupied cells disagree with sample count");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> sample_offset == 32'sd0)
		else $error("rejected reply carries a sample offset");

	a_take_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> offset_valid)
		else $error("accepted sample not reported fresh");

	a_no_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (system_offset != 32'sd1) && (system_offset != -32'sd1))
		else $error("system offset of one second not cleared");

endmodule

[dv/tb_sntp_reply_median_offset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sntp_reply_median_offset_top
// self-checking bench for the sntp reply median offset filter. replies go in
// through a bursty driver and results come out through a stalling receiver.
// every accepted reply runs through a local offset/median predictor and the
// result is compared field by field, in order. the stratum limit and the
// validity window are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_sntp_reply_median_offset_top;
	import sntp_med_pkg::*;

	localparam int WIN           = WINDOW_SIZE_DEF;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 215;

	// indexes the block has no register for, writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct {
		logic [31:0] header;
		logic [31:0] recv_secs;
		logic [30:0] loc_secs;
		bit          drain_first;   // hold this reply back until no result is outstanding
	} reply_t;

	typedef struct {
		logic [1:0] status;
		offset_t    sample;
		offset_t    system;
		logic       valid;
	} offset_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           header_word = '0;
	logic [31:0]           receive_seconds = '0;
	logic [30:0]           local_seconds = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            status;
	logic signed [31:0]    sample_offset;
	logic signed [31:0]    system_offset;
	logic                  offset_valid;

	sntp_reply_median_offset_top #(
		.WINDOW_SIZE(WIN)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.header_word    (header_word),
		.receive_seconds(receive_seconds),
		.local_seconds  (local_seconds),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.sample_offset  (sample_offset),
		.system_offset  (system_offset),
		.offset_valid   (offset_valid)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor state: the sample ring, the held median and the last sync time
	// ------------------------------------------------------------------------
	offset_t     win_samples [WIN];
	int          held_count = 0;
	int          oldest_idx = 0;
	offset_t     held_median = '0;
	logic [30:0] last_sync_secs = '0;
	bit          synced = 1'b0;
	logic [7:0]  stratum_limit = MAX_STRATUM_RST;
	logic [15:0] validity_secs = VALIDITY_RST;

	reply_t         pending_replies [$];
	offset_result_t expected_results [$];

	bit          rst_done = 1'b0;
	logic        in_taken = 1'b0;
	bit          send_bursty = 1'b1;
	bit          out_stalls = 1'b1;
	int          burst_left = 4;
	int          gap_left = 0;
	logic [15:0] stall_pat = 16'h5A5B;
	int          pat_age = 0;
	int          idle_cycles = 0;
	logic [30:0] wall_secs = 31'd5000;

	int errors = 0;
	int n_replies = 0;
	int n_synced = 0;
	int n_alarm = 0;
	int n_stratum = 0;
	int n_fresh = 0;
	int reg_writes = 0;
	int phases = 0;

	// median of the ring, oldest first; even count averages the middle pair
	// toward zero, and a +-1 correction is dropped
	function automatic offset_t window_median();
		longint ranked [WIN];
		longint key;
		longint mid;
		int     i;
		int     k;
		if (held_count == 0)
			return '0;
		for (i = 0; i < held_count; i++)
			ranked[i] = longint'(win_samples[(oldest_idx + i) % WIN]);
		for (i = 1; i < held_count; i++) begin
			key = ranked[i];
			k = i;
			while (k > 0 && ranked[k - 1] > key) begin
				ranked[k] = ranked[k - 1];
				k--;
			end
			ranked[k] = key;
		end
		mid = ranked[held_count / 2];
		if (held_count % 2 == 0)
			mid = (mid + ranked[held_count / 2 - 1]) / 2;
		if (mid == 1 || mid == -1)
			mid = 0;
		return offset_t'(mid[31:0]);
	endfunction

	// screens one reply, updates the ring on acceptance, returns its result
	function automatic offset_result_t predict_offset(input reply_t r);
		offset_result_t res;
		logic [1:0]     leap;
		logic [7:0]     stratum;
		leap = r.header[31:30];
		stratum = r.header[23:16];
		res.sample = '0;
		if (leap == LEAP_ALARM) begin
			res.status = ST_ALARM;
		end else if (stratum == 8'd0 || stratum > stratum_limit) begin
			res.status = ST_STRATUM;
		end else begin
			res.status = ST_OK;
			res.sample = r.recv_secs - {1'b0, r.loc_secs} - EPOCH_GAP;
			if (held_count < WIN) begin
				win_samples[(oldest_idx + held_count) % WIN] = res.sample;
				held_count++;
			end else begin
				win_samples[oldest_idx] = res.sample;
				oldest_idx = (oldest_idx + 1) % WIN;
			end
			held_median = window_median();
			last_sync_secs = r.loc_secs;
			synced = 1'b1;
		end
		res.system = held_median;
		// no wrap on the sum: compare in 64 bits
		res.valid = synced &&
			(longint'(last_sync_secs) + longint'(validity_secs) >= longint'(r.loc_secs));
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------------
	// reply with a chosen offset: receive seconds are derived from it
	function automatic void queue_reply(input logic [1:0] leap, input logic [7:0] stratum,
			input offset_t off, input logic [30:0] secs, input bit drain);
		reply_t r;
		r.header = {leap, 6'($urandom), stratum, 16'($urandom)};
		r.recv_secs = off + {1'b0, secs} + EPOCH_GAP;
		r.loc_secs = secs;
		r.drain_first = drain;
		pending_replies = {pending_replies, r};
	endfunction

	function automatic void queue_raw(input logic [31:0] hdr, input logic [31:0] rcv,
			input logic [30:0] secs, input bit drain);
		reply_t r;
		r.header = hdr;
		r.recv_secs = rcv;
		r.loc_secs = secs;
		r.drain_first = drain;
		pending_replies = {pending_replies, r};
	endfunction

	// runs with the reset register values
	function automatic void queue_directed();
		int i;
		// alarm wins over a zero stratum; nothing synced yet so not valid
		queue_reply(LEAP_ALARM, 8'd0, 5, 31'd1000, 1'b0);
		queue_reply(2'd0, 8'd0, 5, 31'd1000, 1'b0);
		queue_reply(2'd0, 8'd15, 5, 31'd1000, 1'b0);
		queue_reply(LEAP_ALARM, 8'd14, 5, 31'd1000, 1'b0);
		queue_reply(2'd0, 8'd14, 2, 31'd1000, 1'b0);
		// mean of 0 and 2 is 1, which must read back as 0
		queue_reply(2'd1, 8'd1, 0, 31'd1010, 1'b0);
		queue_reply(2'd2, 8'd7, -4, 31'd1020, 1'b0);
		// even count whose middle pair is -4 and 0
		queue_reply(2'd0, 8'd3, -4, 31'd1030, 1'b0);
		queue_reply(2'd0, 8'd9, 32'sh7FFF_FFFF, 31'd1040, 1'b0);
		queue_reply(2'd0, 8'd9, 32'sh8000_0000, 31'd1050, 1'b0);
		// fill the ring and push out the oldest samples
		for (i = 0; i < 5; i++)
			queue_reply(2'd0, 8'(i + 1), offset_t'(i * 1000 - 1), 31'(1060 + 10 * i), 1'b0);
		// rejects right at the end of the validity window and one past it
		queue_reply(2'd0, 8'd200, 0, 31'd1940, 1'b0);
		queue_reply(2'd0, 8'd200, 0, 31'd1941, 1'b0);
		// local time going backwards, held until the pipe is empty
		queue_reply(2'd0, 8'd4, 77, 31'd500, 1'b1);
		queue_reply(2'd0, 8'd200, 0, 31'd0, 1'b0);
		queue_raw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		queue_raw(32'h0000_0000, 32'h0000_0000, 31'h0, 1'b0);
		queue_raw(32'h00FF_0000, 32'h8000_0000, 31'h4000_0000, 1'b0);
	endfunction

	// mostly well-formed replies clustered around one offset so the median
	// means something, plus alarms, bad strata and raw noise
	function automatic void queue_random_phase(input int n, input logic [7:0] lim,
			input logic [15:0] vsecs);
		offset_t    base;
		offset_t    off;
		logic [7:0] strat;
		int         pick;
		int         i;
		bit         drain;
		case ($urandom_range(0, 3))
			0: base = offset_t'($urandom_range(0, 10)) - 5;
			1: base = offset_t'($urandom);
			2: base = $urandom_range(0, 1) ? 32'sh7FFF_FFF0 : 32'sh8000_0008;
			default: base = offset_t'($urandom_range(0, 200000)) - 100000;
		endcase
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			drain = (i == n / 2) || ($urandom_range(0, 199) == 0);
			if (pick < 72) begin
				if ($urandom_range(0, 9) == 0)
					wall_secs += 31'($urandom_range(0, 2 * int'(vsecs) + 2));
				else
					wall_secs += 31'($urandom_range(0, 64));
				if ($urandom_range(0, 15) == 0)
					off = offset_t'($urandom);
				else
					off = base + offset_t'($urandom_range(0, 20)) - 10;
				strat = (lim == 8'd0) ? 8'd1 : 8'($urandom_range(1, int'(lim)));
				queue_reply(2'($urandom_range(0, 2)), strat, off, wall_secs, drain);
			end else if (pick < 82) begin
				queue_reply(LEAP_ALARM, 8'($urandom), offset_t'($urandom), wall_secs, drain);
			end else if (pick < 92) begin
				if (lim == 8'd255 || $urandom_range(0, 3) == 0)
					strat = 8'd0;
				else
					strat = 8'($urandom_range(int'(lim) + 1, 255));
				queue_reply(2'($urandom_range(0, 2)), strat, base, wall_secs, drain);
			end else begin
				queue_raw($urandom, $urandom, 31'($urandom), drain);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// sequencing helpers
	// ------------------------------------------------------------------------
	// wait until nothing is queued, presented or outstanding, let the pipe
	// settle, and look again in case a reply was launched on the same edge
	task automatic settle_idle();
		do begin
			do @(negedge clk);
			while (pending_replies.size() != 0 || in_valid || expected_results.size() != 0);
			repeat (SETTLE_CYCLES) @(negedge clk);
		end while (pending_replies.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic start_phase(input logic [7:0] lim, input logic [15:0] vsecs, input int idx);
		settle_idle();
		write_reg(CFG_MAX_STRATUM, {8'd0, lim});
		write_reg(CFG_VALIDITY, vsecs);
		// every third phase sends back to back, one in four never stalls
		send_bursty = (idx % 3 != 0);
		out_stalls = (idx % 4 != 1);
		phases++;
	endtask

	// ------------------------------------------------------------------------
	// reply driver: bursts of random length; in bursty phases, random gaps in between
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive_replies
		reply_t nxt;
		bit     launch;
		if (rst_done && (!in_valid || in_taken)) begin
			if (in_valid) begin
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					if (send_bursty)
						gap_left = $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
			launch = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (pending_replies.size() != 0)
				launch = !(pending_replies[0].drain_first && expected_results.size() != 0);
			if (launch) begin
				nxt = pending_replies[0];
				pending_replies.delete(0);
				header_word     <= nxt.header;
				receive_seconds <= nxt.recv_secs;
				local_seconds   <= nxt.loc_secs;
				in_valid        <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: rotating stall pattern, reshuffled now and then,
	// always with at least one ready slot; ready throughout in phases that never stall
	always @(negedge clk) begin : drive_out_ready
		if (out_stalls) begin
			out_ready <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			pat_age++;
			if (pat_age == 40) begin
				pat_age = 0;
				stall_pat = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
			end
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: register writes, reply transactions, result checks, watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		offset_result_t want;
		reply_t         seen;
		if (rst_done) begin
			in_taken <= in_valid && in_ready;

			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					CFG_MAX_STRATUM: stratum_limit = cfg_data[7:0];
					CFG_VALIDITY:    validity_secs = cfg_data;
					default: ;
				endcase
			end

			// results first: a result on this edge always belongs to an older reply
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no reply outstanding");
					errors++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, status);
						errors++;
					end
					if (sample_offset !== want.sample) begin
						$error("sample_offset: expected %0d actual %0d", want.sample, sample_offset);
						errors++;
					end
					if (system_offset !== want.system) begin
						$error("system_offset: expected %0d actual %0d", want.system, system_offset);
						errors++;
					end
					if (offset_valid !== want.valid) begin
						$error("offset_valid: expected %0d actual %0d", want.valid, offset_valid);
						errors++;
					end
				end
			end

			if (in_valid && in_ready) begin
				seen.header = header_word;
				seen.recv_secs = receive_seconds;
				seen.loc_secs = local_seconds;
				seen.drain_first = 1'b0;
				want = predict_offset(seen);
				n_replies++;
				case (want.status)
					ST_OK:      n_synced++;
					ST_ALARM:   n_alarm++;
					ST_STRATUM: n_stratum++;
					default: ;
				endcase
				if (want.valid)
					n_fresh++;
				expected_results = {expected_results, want};
			end

			// nothing moving on any channel for too long means a hang
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout after %0d idle cycles", idle_cycles);
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin : run_test
		int p;
		for (p = 0; p < WIN; p++)
			win_samples[p] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		rst_done = 1'b1;

		// reset values of both registers, directed corners
		queue_directed();

		// widest settings, then the no-wrap check at the top of local time
		start_phase(8'd255, 16'hFFFF, 1);
		queue_reply(2'd0, 8'd255, 12, 31'h7FFF_FFFF, 1'b0);
		queue_reply(LEAP_ALARM, 8'd1, 0, 31'h7FFF_FFFF, 1'b0);
		queue_reply(2'd0, 8'd0, 0, 31'd100, 1'b0);
		queue_random_phase(PHASE_ITEMS, 8'd255, 16'hFFFF);

		// tightest real limit and a zero validity window
		start_phase(8'd1, 16'd0, 2);
		queue_random_phase(PHASE_ITEMS, 8'd1, 16'd0);

		// limit of zero rejects everything; spare indexes must be ignored
		start_phase(8'd0, VALIDITY_RST, 3);
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_SPARE_B, 16'($urandom));
		queue_random_phase(60, 8'd0, VALIDITY_RST);

		start_phase(8'd8, 16'd100, 4);
		queue_random_phase(PHASE_ITEMS, 8'd8, 16'd100);

		start_phase(MAX_STRATUM_RST, VALIDITY_RST, 5);
		queue_random_phase(PHASE_ITEMS, MAX_STRATUM_RST, VALIDITY_RST);

		for (p = 6; p < 10; p++) begin : random_settings
			logic [7:0]  lim;
			logic [15:0] vsecs;
			lim = 8'($urandom_range(1, 255));
			vsecs = 16'($urandom);
			start_phase(lim, vsecs, p);
			queue_random_phase(PHASE_ITEMS, lim, vsecs);
		end

		settle_idle();
		$display("covered %0d replies: %0d synced, %0d alarm, %0d stratum rejects, %0d fresh",
			n_replies, n_synced, n_alarm, n_stratum, n_fresh);
		$display("%0d register writes across %0d reconfigured phases", reg_writes, phases);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
